// ----- src/tpq_pkg.sv -----
// Package for the two-priority packet transmit queue.
// Command, result and state codes plus default sizing constants.
// No dependencies.
package tpq_pkg;

	localparam int HIGH_SLOTS_DEF  = 4;
	localparam int LOW_SLOTS_DEF   = 4;
	localparam int MAX_PAYLOAD_DEF = 32;

	typedef enum logic [1:0] {
		CMD_PUSH_HIGH = 2'd0,
		CMD_PUSH_LOW  = 2'd1,
		CMD_SEND      = 2'd2,
		CMD_DONE      = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ACCEPT = 2'd0,
		KIND_REJECT = 2'd1,
		KIND_TX     = 2'd2,
		KIND_RX     = 2'd3
	} kind_t;

	typedef enum logic {
		ST_IDLE   = 1'b0,
		ST_STREAM = 1'b1
	} state_t;

endpackage

// ----- src/two_priority_packet_tx_queue.sv -----
// Push result is registered and shown in the cycle after the transfer; a send's first byte
// passes the sequencer state, memory read and output registers. Throughput: one push byte
// per cycle while the output is not stalled; a send holds the input until its packet is read out.
// Reset (arst_n low): queues empty, fill counts zero, radio idle, output empty.
// Byte memories and length entries are undefined until written.
// Depends on tpq_pkg.
module two_priority_packet_tx_queue #(
	parameter int HIGH_QUEUE_SLOTS = tpq_pkg::HIGH_SLOTS_DEF,
	parameter int LOW_QUEUE_SLOTS  = tpq_pkg::LOW_SLOTS_DEF,
	parameter int MAX_PAYLOAD      = tpq_pkg::MAX_PAYLOAD_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] data_byte,
	input  logic       byte_last,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [1:0] kind,
	output logic [7:0] tx_byte,
	output logic       tx_last
);

	localparam int HIDX_W  = $clog2(HIGH_QUEUE_SLOTS);
	localparam int LIDX_W  = $clog2(LOW_QUEUE_SLOTS);
	localparam int LEN_W   = $clog2(MAX_PAYLOAD + 1);
	localparam int HDEPTH  = HIGH_QUEUE_SLOTS * MAX_PAYLOAD;
	localparam int LDEPTH  = LOW_QUEUE_SLOTS * MAX_PAYLOAD;
	localparam int HADDR_W = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
	localparam int LADDR_W = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
	localparam logic [LEN_W-1:0]  MAXP    = LEN_W'(MAX_PAYLOAD);
	localparam logic [HIDX_W-1:0] HI_LAST = HIDX_W'(HIGH_QUEUE_SLOTS - 1);
	localparam logic [LIDX_W-1:0] LO_LAST = LIDX_W'(LOW_QUEUE_SLOTS - 1);

	logic [7:0] hi_mem [HDEPTH];
	logic [7:0] lo_mem [LDEPTH];
	logic [LEN_W-1:0] hi_len_q [HIGH_QUEUE_SLOTS];
	logic [LEN_W-1:0] lo_len_q [LOW_QUEUE_SLOTS];

	logic [HIDX_W-1:0] hi_head_q, hi_tail_q, hi_tail_nxt;
	logic [LIDX_W-1:0] lo_head_q, lo_tail_q, lo_tail_nxt;
	logic [LEN_W-1:0]  hi_fill_q, lo_fill_q;
	logic              busy_q;

	tpq_pkg::state_t state_q, state_nxt;
	logic [LEN_W-1:0] pos_q, len_q;
	logic             sel_low_q;

	logic             rd_vld_s1, last_s1, sel_low_s1;
	logic [7:0]       hi_rdata_s1, lo_rdata_s1;

	logic             out_valid_q, tx_last_q;
	tpq_pkg::kind_t   kind_q, res_kind;
	logic [7:0]       tx_byte_q;

	logic acc, out_free, s1_free, rd_issue, rd_final;
	logic push_hi, push_lo, send, busy_eff, hi_nonempty, lo_nonempty;
	logic hi_reject, lo_reject, hi_we, lo_we;
	logic start_hi, start_lo, res_now;
	logic [HADDR_W-1:0] hi_waddr, hi_raddr;
	logic [LADDR_W-1:0] lo_waddr, lo_raddr;

	// decode
	always_comb begin
		out_free    = !out_valid_q || !result_stall;
		s1_free     = !rd_vld_s1 || out_free;
		acc         = item_valid && !item_stall;
		push_hi     = cmd == tpq_pkg::CMD_PUSH_HIGH;
		push_lo     = cmd == tpq_pkg::CMD_PUSH_LOW;
		send        = (cmd == tpq_pkg::CMD_SEND) || (cmd == tpq_pkg::CMD_DONE);
		busy_eff    = (cmd == tpq_pkg::CMD_SEND) && busy_q;
		hi_nonempty = hi_head_q != hi_tail_q;
		lo_nonempty = lo_head_q != lo_tail_q;
		hi_tail_nxt = (hi_tail_q == HI_LAST) ? '0 : hi_tail_q + 1'b1;
		lo_tail_nxt = (lo_tail_q == LO_LAST) ? '0 : lo_tail_q + 1'b1;
		hi_reject   = (hi_fill_q == MAXP) || (hi_tail_nxt == hi_head_q);
		lo_reject   = (lo_fill_q == MAXP) || (lo_tail_nxt == lo_head_q);
		hi_we       = acc && push_hi && (byte_last ? !hi_reject : (hi_fill_q != MAXP));
		lo_we       = acc && push_lo && (byte_last ? !lo_reject : (lo_fill_q != MAXP));
		start_hi    = acc && send && !busy_eff && hi_nonempty;
		start_lo    = acc && send && !busy_eff && !hi_nonempty && lo_nonempty;
		hi_waddr    = HADDR_W'(hi_tail_q * MAX_PAYLOAD) + HADDR_W'(hi_fill_q);
		lo_waddr    = LADDR_W'(lo_tail_q * MAX_PAYLOAD) + LADDR_W'(lo_fill_q);
		hi_raddr    = HADDR_W'(hi_head_q * MAX_PAYLOAD) + HADDR_W'(pos_q);
		lo_raddr    = LADDR_W'(lo_head_q * MAX_PAYLOAD) + LADDR_W'(pos_q);
		rd_final    = pos_q == (len_q - 1'b1);
		res_now     = 1'b0;
		res_kind    = tpq_pkg::KIND_ACCEPT;
		if (acc) begin
			if ((push_hi || push_lo) && byte_last) begin
				res_now  = 1'b1;
				res_kind = (push_hi ? hi_reject : lo_reject) ?
					tpq_pkg::KIND_REJECT : tpq_pkg::KIND_ACCEPT;
			end else if (send && !busy_eff && !hi_nonempty && !lo_nonempty) begin
				res_now  = 1'b1;
				res_kind = tpq_pkg::KIND_RX;
			end
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tpq_pkg::ST_IDLE: begin
				if (start_hi || start_lo) state_nxt = tpq_pkg::ST_STREAM;
			end
			tpq_pkg::ST_STREAM: begin
				if (rd_issue && rd_final) state_nxt = tpq_pkg::ST_IDLE;
			end
			default: state_nxt = tpq_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer; input held while a packet is in flight or the output is stalled
	always_comb begin
		rd_issue   = 1'b0;
		item_stall = 1'b1;
		unique case (state_q)
			tpq_pkg::ST_IDLE: begin
				item_stall = rd_vld_s1 || (out_valid_q && result_stall);
			end
			tpq_pkg::ST_STREAM: begin
				rd_issue = s1_free;
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (hi_we) hi_mem[hi_waddr] <= data_byte;
		if (rd_issue && !sel_low_q) hi_rdata_s1 <= hi_mem[hi_raddr];
	end

	always_ff @(posedge clk) begin
		if (lo_we) lo_mem[lo_waddr] <= data_byte;
		if (rd_issue && sel_low_q) lo_rdata_s1 <= lo_mem[lo_raddr];
	end

	always_ff @(posedge clk) begin
		if (hi_we && byte_last) hi_len_q[hi_tail_q] <= hi_fill_q + 1'b1;
		if (lo_we && byte_last) lo_len_q[lo_tail_q] <= lo_fill_q + 1'b1;
		if (start_hi || start_lo) begin
			len_q     <= start_hi ? hi_len_q[hi_head_q] : lo_len_q[lo_head_q];
			sel_low_q <= start_lo;
		end
		if (rd_issue) begin
			last_s1    <= rd_final;
			sel_low_s1 <= sel_low_q;
		end
		if (rd_vld_s1 && out_free) begin
			kind_q    <= tpq_pkg::KIND_TX;
			tx_byte_q <= sel_low_s1 ? lo_rdata_s1 : hi_rdata_s1;
			tx_last_q <= last_s1;
		end else if (res_now) begin
			kind_q    <= res_kind;
			tx_byte_q <= '0;
			tx_last_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tpq_pkg::ST_IDLE;
			hi_head_q   <= '0;
			hi_tail_q   <= '0;
			lo_head_q   <= '0;
			lo_tail_q   <= '0;
			hi_fill_q   <= '0;
			lo_fill_q   <= '0;
			busy_q      <= 1'b0;
			pos_q       <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (acc && push_hi) begin
				if (byte_last) begin
					hi_fill_q <= '0;
					if (!hi_reject) hi_tail_q <= hi_tail_nxt;
				end else if (hi_fill_q != MAXP) begin
					hi_fill_q <= hi_fill_q + 1'b1;
				end
			end
			if (acc && push_lo) begin
				if (byte_last) begin
					lo_fill_q <= '0;
					if (!lo_reject) lo_tail_q <= lo_tail_nxt;
				end else if (lo_fill_q != MAXP) begin
					lo_fill_q <= lo_fill_q + 1'b1;
				end
			end
			if (start_hi || start_lo) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end else if (acc && cmd == tpq_pkg::CMD_DONE) begin
				busy_q <= 1'b0;
			end
			if (rd_issue) begin
				pos_q <= pos_q + 1'b1;
				if (rd_final) begin
					if (sel_low_q) lo_head_q <= (lo_head_q == LO_LAST) ? '0 : lo_head_q + 1'b1;
					else           hi_head_q <= (hi_head_q == HI_LAST) ? '0 : hi_head_q + 1'b1;
				end
			end
			if (rd_issue)      rd_vld_s1 <= 1'b1;
			else if (out_free) rd_vld_s1 <= 1'b0;
			if (rd_vld_s1 && out_free) out_valid_q <= 1'b1;
			else if (res_now)          out_valid_q <= 1'b1;
			else if (out_free)         out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign kind         = kind_q;
	assign tx_byte      = tx_byte_q;
	assign tx_last      = tx_last_q;

endmodule
